// ===== rtl/dual_slot_record_validate_select_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual-slot record validate and select core
// Same-cycle implication and next-cycle implication checks on one clock.
// ----------------------------------------------------------------------------
`ifndef DUAL_SLOT_RECORD_VALIDATE_SELECT_CORE_ASSERT_SVH
`define DUAL_SLOT_RECORD_VALIDATE_SELECT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DSRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DSRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DSRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/dsrv_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrv_pkg
// Widths, codes, status types and the CRC16-CCITT byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrv_pkg;

    localparam int BYTE_W          = 8;
    localparam int ID_W            = 32;
    localparam int GEN_W           = 16;
    localparam int SCORE_W         = 16;
    localparam int CRC_W           = 16;
    localparam int SLOT_W          = 2;
    localparam int IDX_W           = 3;
    localparam int POS_W           = 5;
    localparam int DEF_SCORE_COUNT = 5;

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [BYTE_W-1:0] MARKER    = 8'hA5;
    localparam logic [BYTE_W-1:0] VERSION   = 8'h01;
    localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd2;

    typedef struct packed {
        logic              done;
        logic              valid;
        logic              slot;
        logic              at_last;
    } t_rec_stat;

    typedef struct packed {
        logic              valid;
        logic              adopt;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
    } t_sel_view;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dsrv_ifs.sv =====
// ----------------------------------------------------------------------------
// dsrv channel interfaces
// Record byte channel and score result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsrv_in_if;
    import dsrv_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic              record_slot;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, kind, record_slot, data_byte, input ready);
    modport sink   (input valid, kind, record_slot, data_byte, output ready);
endinterface

interface dsrv_out_if;
    import dsrv_pkg::*;

    logic               valid;
    logic               ready;
    logic               record_valid;
    logic               record_adopted;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [GEN_W-1:0]   chosen_generation;
    logic [IDX_W-1:0]   score_index;
    logic [SCORE_W-1:0] score_value;
    logic               last_of_run;

    modport source (output valid, record_valid, record_adopted, chosen_slot,
                    chosen_generation, score_index, score_value, last_of_run,
                    input ready);
    modport sink   (input valid, record_valid, record_adopted, chosen_slot,
                    chosen_generation, score_index, score_value, last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_slot_record_validate_select_core.sv =====
// The first result word of a record leaves in the cycle after its last byte is accepted.
// Throughput: one record byte or begin-scan word per cycle while i_rec.ready is high; SCORE_COUNT
// result words per record, one per cycle while o_res.ready is high, from the result buffer.
// The last byte of a record waits only while the previous record's results are still queued.
// Reset (i_rst_n low, synchronous): parser to byte 0, selection to none, project id to 0.
// ----------------------------------------------------------------------------
// dual_slot_record_validate_select_core
// Validates saved records byte by byte and tracks the newest valid slot.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_slot_record_validate_select_core_assert.svh"

module dual_slot_record_validate_select_core #(
    parameter int SCORE_COUNT = dsrv_pkg::DEF_SCORE_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dsrv_pkg::ID_W-1:0] i_cfg_wdata,
    dsrv_in_if.sink                   i_rec,
    dsrv_out_if.source                o_res
);
    import dsrv_pkg::*;

    logic [ID_W-1:0]    r_project_id;
    t_rec_stat          w_stat;
    t_sel_view          w_view;
    logic [GEN_W-1:0]   w_gen;
    logic [SCORE_W-1:0] w_rec_scores [SCORE_COUNT];
    logic [SCORE_W-1:0] w_sel_scores [SCORE_COUNT];
    logic               w_busy;
    logic               w_acc;
    logic               w_byte_acc;
    logic               w_begin_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_project_id <= '0;
        end else if (i_cfg_we) begin
            r_project_id <= i_cfg_wdata;
        end
    end

    assign i_rec.ready = !(w_busy && w_stat.at_last);
    assign w_acc       = i_rec.valid && i_rec.ready;
    assign w_byte_acc  = w_acc && i_rec.kind;
    assign w_begin_acc = w_acc && !i_rec.kind;

    dsrv_parse #(.SCORE_COUNT(SCORE_COUNT)) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_acc   (w_byte_acc),
        .i_begin_acc  (w_begin_acc),
        .i_slot       (i_rec.record_slot),
        .i_byte       (i_rec.data_byte),
        .i_project_id (r_project_id),
        .o_stat       (w_stat),
        .o_gen        (w_gen),
        .o_scores     (w_rec_scores)
    );

    dsrv_select #(.SCORE_COUNT(SCORE_COUNT)) u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_begin_acc),
        .i_stat   (w_stat),
        .i_gen    (w_gen),
        .i_scores (w_rec_scores),
        .o_view   (w_view),
        .o_scores (w_sel_scores)
    );

    dsrv_emit #(.SCORE_COUNT(SCORE_COUNT)) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_stat.done),
        .i_view   (w_view),
        .i_scores (w_sel_scores),
        .o_busy   (w_busy),
        .o_res    (o_res)
    );

    `DSRV_ASSERT_IMP(a_adopt_needs_valid, i_clk, i_rst_n, o_res.valid && o_res.record_adopted, o_res.record_valid)
    `DSRV_ASSERT_IMP(a_last_index, i_clk, i_rst_n, o_res.valid && o_res.last_of_run, o_res.score_index == IDX_W'(SCORE_COUNT - 1))
    `DSRV_ASSERT_IMP(a_none_is_zero, i_clk, i_rst_n, o_res.valid && (o_res.chosen_slot == SLOT_NONE), (o_res.chosen_generation == '0) && (o_res.score_value == '0))
    `DSRV_ASSERT_NXT(a_begin_restarts, i_clk, i_rst_n, w_begin_acc, !w_stat.at_last)

endmodule

`default_nettype wire

// ===== rtl/dsrv_parse.sv =====
// ----------------------------------------------------------------------------
// dsrv_parse
// Byte-wise record parser: position, running CRC, field checks, field capture.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrv_parse #(
    parameter int SCORE_COUNT = dsrv_pkg::DEF_SCORE_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_byte_acc,
    input  logic                         i_begin_acc,
    input  logic                         i_slot,
    input  logic [dsrv_pkg::BYTE_W-1:0]  i_byte,
    input  logic [dsrv_pkg::ID_W-1:0]    i_project_id,
    output dsrv_pkg::t_rec_stat          o_stat,
    output logic [dsrv_pkg::GEN_W-1:0]   o_gen,
    output logic [dsrv_pkg::SCORE_W-1:0] o_scores [SCORE_COUNT]
);
    import dsrv_pkg::*;

    localparam int REC_LEN  = 10 + 2 * SCORE_COUNT;
    localparam int CRC_LAST = 7 + 2 * SCORE_COUNT;
    localparam logic [POS_W-1:0] P_LEN   = POS_W'(REC_LEN);
    localparam logic [POS_W-1:0] P_LAST  = POS_W'(REC_LEN - 1);
    localparam logic [POS_W-1:0] P_CRCL  = POS_W'(CRC_LAST);
    localparam logic [POS_W-1:0] P_CRCH  = POS_W'(CRC_LAST + 1);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic               r_ok, n_ok;
    logic [BYTE_W-1:0]  r_low, n_low;
    logic               r_slot, n_slot;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic [SCORE_W-1:0] r_last, n_last;
    logic [SCORE_W-1:0] r_scores [SCORE_COUNT];
    logic [SCORE_W-1:0] n_scores [SCORE_COUNT];

    logic [POS_W-1:0]   p;
    logic [15:0]        word;
    logic [1:0]         id_idx;
    logic [BYTE_W-1:0]  id_byte;
    logic [IDX_W-1:0]   s;

    always_comb begin
        p       = (r_pos >= P_LEN) ? '0 : r_pos;
        word    = {i_byte, r_low};
        id_idx  = 2'(p - POS_W'(2));
        id_byte = i_project_id[{id_idx, 3'b000} +: BYTE_W];
        s       = IDX_W'((p - POS_W'(9)) >> 1);

        n_pos    = r_pos;
        n_crc    = r_crc;
        n_ok     = r_ok;
        n_low    = r_low;
        n_slot   = r_slot;
        n_gen    = r_gen;
        n_last   = r_last;
        n_scores = r_scores;

        if (i_begin_acc) begin
            n_pos = '0;
            n_crc = CRC_INIT;
            n_ok  = 1'b1;
        end else if (i_byte_acc) begin
            if (p == '0) begin
                n_slot = i_slot;
                n_crc  = CRC_INIT;
                n_ok   = (i_byte == MARKER);
            end else begin
                if (p <= P_CRCL) begin
                    n_crc = crc_byte(r_crc, i_byte);
                end
                if (p == POS_W'(1)) begin
                    if (i_byte != VERSION) begin
                        n_ok = 1'b0;
                    end
                end else if (p <= POS_W'(5)) begin
                    if (i_byte != id_byte) begin
                        n_ok = 1'b0;
                    end
                end else if (p <= P_CRCL) begin
                    if (!p[0]) begin
                        n_low = i_byte;
                    end else if (p == POS_W'(7)) begin
                        n_gen = word;
                    end else begin
                        n_scores[s] = word;
                        n_last      = word;
                        if (p != POS_W'(9) && word > r_last) begin
                            n_ok = 1'b0;
                        end
                    end
                end else if (p == P_CRCH) begin
                    n_low = i_byte;
                end
            end
            if (p == P_LAST) begin
                n_pos = '0;
                n_crc = CRC_INIT;
                n_ok  = 1'b1;
            end else begin
                n_pos = p + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= CRC_INIT;
            r_ok   <= 1'b1;
            r_low  <= '0;
            r_slot <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_ok   <= n_ok;
            r_low  <= n_low;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gen    <= n_gen;
        r_last   <= n_last;
        r_scores <= n_scores;
    end

    assign o_stat.done    = i_byte_acc && (p == P_LAST);
    assign o_stat.valid   = r_ok && (r_crc == word);
    assign o_stat.slot    = r_slot;
    assign o_stat.at_last = (p == P_LAST);
    assign o_gen          = r_gen;
    assign o_scores       = r_scores;

endmodule

`default_nettype wire

// ===== rtl/dsrv_select.sv =====
// ----------------------------------------------------------------------------
// dsrv_select
// Selection register: adopt valid record if none held or serially newer gen.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrv_select #(
    parameter int SCORE_COUNT = dsrv_pkg::DEF_SCORE_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  dsrv_pkg::t_rec_stat          i_stat,
    input  logic [dsrv_pkg::GEN_W-1:0]   i_gen,
    input  logic [dsrv_pkg::SCORE_W-1:0] i_scores [SCORE_COUNT],
    output dsrv_pkg::t_sel_view          o_view,
    output logic [dsrv_pkg::SCORE_W-1:0] o_scores [SCORE_COUNT]
);
    import dsrv_pkg::*;

    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic [SCORE_W-1:0] r_scores [SCORE_COUNT];
    logic [SCORE_W-1:0] n_scores [SCORE_COUNT];
    logic [GEN_W-1:0]   delta;
    logic               adopt;

    always_comb begin
        delta    = i_gen - r_gen;
        adopt    = i_stat.done && i_stat.valid &&
                   ((r_slot == SLOT_NONE) || ((delta != '0) && !delta[GEN_W-1]));
        n_slot   = r_slot;
        n_gen    = r_gen;
        n_scores = r_scores;
        priority if (i_clear) begin
            n_slot = SLOT_NONE;
            n_gen  = '0;
            for (int i = 0; i < SCORE_COUNT; i++) begin
                n_scores[i] = '0;
            end
        end else if (adopt) begin
            n_slot   = {1'b0, i_stat.slot};
            n_gen    = i_gen;
            n_scores = i_scores;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_NONE;
            r_gen  <= '0;
            for (int i = 0; i < SCORE_COUNT; i++) begin
                r_scores[i] <= '0;
            end
        end else begin
            r_slot   <= n_slot;
            r_gen    <= n_gen;
            r_scores <= n_scores;
        end
    end

    assign o_view.valid = i_stat.valid;
    assign o_view.adopt = adopt;
    assign o_view.slot  = n_slot;
    assign o_view.gen   = n_gen;
    assign o_scores     = n_scores;

endmodule

`default_nettype wire

// ===== rtl/dsrv_emit.sv =====
// ----------------------------------------------------------------------------
// dsrv_emit
// Result buffer: snapshot of one record's outcome, sent as one word per score.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrv_emit #(
    parameter int SCORE_COUNT = dsrv_pkg::DEF_SCORE_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  dsrv_pkg::t_sel_view          i_view,
    input  logic [dsrv_pkg::SCORE_W-1:0] i_scores [SCORE_COUNT],
    output logic                         o_busy,
    dsrv_out_if.source                   o_res
);
    import dsrv_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCORE_COUNT - 1);

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    t_sel_view          r_view;
    logic [SCORE_W-1:0] r_sc [SCORE_COUNT];
    logic               last;
    logic               take;

    assign last = (r_idx == IDX_LAST);
    assign take = r_busy && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_view <= i_view;
            r_sc   <= i_scores;
        end else if (take) begin
            for (int k = 0; k < SCORE_COUNT - 1; k++) begin
                r_sc[k] <= r_sc[k+1];
            end
        end
    end

    assign o_busy                  = r_busy;
    assign o_res.valid             = r_busy;
    assign o_res.record_valid      = r_view.valid;
    assign o_res.record_adopted    = r_view.adopt;
    assign o_res.chosen_slot       = r_view.slot;
    assign o_res.chosen_generation = r_view.gen;
    assign o_res.score_index       = r_idx;
    assign o_res.score_value       = r_sc[0];
    assign o_res.last_of_run       = last;

endmodule

`default_nettype wire
